@@ sv/swm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the stack with minimum tracking: stack
// sizing, request and status codes, and the controller to datapath command
// and status structs.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Stack sizing. Counts hold 0..STACK_DEPTH, indexes 0..STACK_DEPTH-1.
  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  // Port field widths.
  localparam int DATA_W = 32;
  localparam int REQ_W  = 2;
  localparam int OCC_W  = 7;
  localparam int STS_W  = 2;

  // Request codes. The unused code behaves as a peek.
  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_RESP
  } state_e;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_KEEP,
    OP_PUSH,
    OP_POP,
    OP_LOAD,
    OP_RESP
  } op_e;

  typedef struct packed {
    op_e     op;
    status_e status;
  } swm_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } swm_stat_t;

endpackage

@@ sv/swm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer for the stack: accepts one request at a time, issues push, pop
// and refill operations to the datapath, and owns the result valid flag.
// ----------------------------------------------------------------------------
module swm_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [swm_pkg::REQ_W-1:0] req_type_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  swm_pkg::swm_stat_t       stat_i,
  output swm_pkg::swm_cmd_t        cmd_o
);
  import swm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // State and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A new request is taken only once the previous result has left or is
  // leaving in this cycle.
  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_o.op      = OP_NONE;
    cmd_o.status  = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RESP;
          priority if (req_type_i == REQ_PUSH) begin
            if (stat_i.full) begin
              cmd_o.op     = OP_KEEP;
              cmd_o.status = ST_OVERFLOW;
            end else begin
              cmd_o.op = OP_PUSH;
            end
          end else if (req_type_i == REQ_POP) begin
            if (stat_i.empty) begin
              cmd_o.op     = OP_KEEP;
              cmd_o.status = ST_UNDERFLOW;
            end else begin
              cmd_o.op = OP_POP;
              state_d  = S_LOAD;
            end
          end else begin
            // Peek and the unused code leave the stack alone.
            cmd_o.op = OP_KEEP;
          end
        end
      end
      S_LOAD: begin
        // Memory read data for the new tops is available now.
        cmd_o.op = OP_LOAD;
        state_d  = S_RESP;
      end
      S_RESP: begin
        cmd_o.op    = OP_RESP;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/swm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_datapath
// Value and minima stores with cached top registers, the stack counts and
// the result register.
// ----------------------------------------------------------------------------
module swm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  swm_pkg::swm_cmd_t                 cmd_i,
  output swm_pkg::swm_stat_t                stat_o,
  input  logic signed [swm_pkg::DATA_W-1:0] push_value_i,
  output logic signed [swm_pkg::DATA_W-1:0] top_value_o,
  output logic signed [swm_pkg::DATA_W-1:0] min_value_o,
  output logic                              is_empty_o,
  output logic [swm_pkg::OCC_W-1:0]         occupancy_o,
  output logic [swm_pkg::STS_W-1:0]         status_o
);
  import swm_pkg::*;

  logic [DATA_W-1:0] val_mem [STACK_DEPTH];
  logic [DATA_W-1:0] min_mem [STACK_DEPTH];

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  mcnt_q, mcnt_d;
  logic [DATA_W-1:0] top_q, top_d;
  logic [DATA_W-1:0] mtop_q, mtop_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] rd_val_q;
  logic [DATA_W-1:0] rd_min_q;

  logic              take_min;
  logic              drop_min;
  logic              val_we;
  logic              min_we;
  logic [IDX_W-1:0]  val_wr_idx;
  logic [IDX_W-1:0]  min_wr_idx;
  logic [CNT_W-1:0]  val_rd_cnt;
  logic [CNT_W-1:0]  min_rd_cnt;
  logic [IDX_W-1:0]  val_rd_idx;
  logic [IDX_W-1:0]  min_rd_idx;

  assign stat_o.full  = (cnt_q == CNT_W'(STACK_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // A pushed value joins the minima when it is no greater than their top.
  assign take_min = (mcnt_q == '0) ||
                    ($signed(push_value_i) <= $signed(mtop_q));
  // A popped value leaves the minima when it equals their top.
  assign drop_min = (mcnt_q != '0) && (mtop_q == top_q);

  assign val_we     = (cmd_i.op == OP_PUSH);
  assign min_we     = val_we && take_min && (mcnt_q < CNT_W'(STACK_DEPTH));
  assign val_wr_idx = cnt_q[IDX_W-1:0];
  assign min_wr_idx = mcnt_q[IDX_W-1:0];

  // Read addresses for the entries that become the tops after a pop.
  assign val_rd_cnt = cnt_q - CNT_W'(2);
  assign min_rd_cnt = drop_min ? (mcnt_q - CNT_W'(2)) : (mcnt_q - CNT_W'(1));
  assign val_rd_idx = val_rd_cnt[IDX_W-1:0];
  assign min_rd_idx = min_rd_cnt[IDX_W-1:0];

  // Stores: one write port each, registered read.
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wr_idx] <= push_value_i;
    end
    if (min_we) begin
      min_mem[min_wr_idx] <= push_value_i;
    end
    rd_val_q <= val_mem[val_rd_idx];
    rd_min_q <= min_mem[min_rd_idx];
  end

  // Counts, cached tops and request status.
  always_comb begin
    cnt_d    = cnt_q;
    mcnt_d   = mcnt_q;
    top_d    = top_q;
    mtop_d   = mtop_q;
    status_d = status_q;
    unique case (cmd_i.op)
      OP_KEEP: begin
        status_d = cmd_i.status;
      end
      OP_PUSH: begin
        status_d = ST_OK;
        cnt_d    = cnt_q + CNT_W'(1);
        top_d    = push_value_i;
        if (min_we) begin
          mcnt_d = mcnt_q + CNT_W'(1);
          mtop_d = push_value_i;
        end
      end
      OP_POP: begin
        status_d = ST_OK;
        cnt_d    = cnt_q - CNT_W'(1);
        if (drop_min) begin
          mcnt_d = mcnt_q - CNT_W'(1);
        end
      end
      OP_LOAD: begin
        top_d  = rd_val_q;
        mtop_d = rd_min_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      mcnt_q   <= '0;
      status_q <= ST_OK;
    end else begin
      cnt_q    <= cnt_d;
      mcnt_q   <= mcnt_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    mtop_q <= mtop_d;
  end

  // Result register, loaded once the stack has settled.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RESP) begin
      top_value_o <= (cnt_q == '0) ? '1 : top_q;
      min_value_o <= ((cnt_q == '0) || (mcnt_q == '0)) ? '1 : mtop_q;
      is_empty_o  <= (cnt_q == '0);
      occupancy_o <= OCC_W'(cnt_q);
      status_o    <= status_q;
    end
  end

endmodule

@@ sv/stack_with_minimum_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_minimum_core
// Bounded LIFO stack of signed 32-bit values that reports its current
// minimum with every request, using a second stack of minima.
//
//   Channel   Direction  Handshake               Payload
//   in        request    in_valid_i / in_stall_o  req_type_i, push_value_i
//   out       result     out_valid_o / out_stall_i top_value_o, min_value_o,
//                                                 is_empty_o, occupancy_o,
//                                                 status_o
//
// Push, peek and refused requests pass from acceptance to S_RESP, which
// loads the result register and raises the result valid; a pop first passes
// through S_LOAD, for the registered store read that refills the cached tops.
// One request is in flight at a time; the next is taken once back in S_IDLE.
// Reset clears both counts; the stores need no clearing pass.
// A stalled result holds off the next request until it is taken.
// ----------------------------------------------------------------------------
module stack_with_minimum_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [swm_pkg::REQ_W-1:0]         req_type_i,
  input  logic signed [swm_pkg::DATA_W-1:0] push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [swm_pkg::DATA_W-1:0] top_value_o,
  output logic signed [swm_pkg::DATA_W-1:0] min_value_o,
  output logic                              is_empty_o,
  output logic [swm_pkg::OCC_W-1:0]         occupancy_o,
  output logic [swm_pkg::STS_W-1:0]         status_o
);
  import swm_pkg::*;

  swm_cmd_t  cmd;
  swm_stat_t stat;

  // Request sequencing.
  swm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Stores, counts and result register.
  swm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .push_value_i (push_value_i),
    .top_value_o  (top_value_o),
    .min_value_o  (min_value_o),
    .is_empty_o   (is_empty_o),
    .occupancy_o  (occupancy_o),
    .status_o     (status_o)
  );

endmodule

@@ dv/stack_with_minimum_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_minimum_core_tb
// Self-checking bench for the stack with minimum tracking. Each accepted
// request is run through a shadow stack kept in the bench, and every result
// is compared field by field with the oldest predicted stack view. Directed
// requests cover the empty stack, value extremes and equal minima. Random
// traffic then fills the stack past full and drains it past empty, under
// several sender and receiver idle mixes; a directed test holds the receiver off.
// ----------------------------------------------------------------------------
module stack_with_minimum_core_tb;
  import swm_pkg::*;

  // The request code that the block treats as a peek.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE_TAIL  = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 266;
  localparam int MAX_GAP      = 10;

  // Traffic shapes for the random part.
  typedef enum int {
    TRAFFIC_FILL,
    TRAFFIC_DRAIN,
    TRAFFIC_MIXED
  } traffic_e;

  // What the block reports after one request.
  typedef struct {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic [OCC_W-1:0]         occupancy;
    status_e                  status;
  } stack_view_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic [REQ_W-1:0]         req_type_i   = REQ_PEEK;
  logic signed [DATA_W-1:0] push_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic signed [DATA_W-1:0] top_value_o;
  logic signed [DATA_W-1:0] min_value_o;
  logic                     is_empty_o;
  logic [OCC_W-1:0]         occupancy_o;
  logic [STS_W-1:0]         status_o;

  // Shadow copy of both stacks.
  logic signed [DATA_W-1:0] shadow_values [STACK_DEPTH];
  logic signed [DATA_W-1:0] shadow_minima [STACK_DEPTH];
  int                       shadow_count     = 0;
  int                       shadow_min_count = 0;

  stack_view_t pending_views[$];
  status_e     last_status;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  bit hold_requested    = 1'b0;
  int mismatch_count    = 0;
  int cycle_count       = 0;
  int push_count        = 0;
  int pop_count         = 0;
  int peek_count        = 0;
  int overflow_count    = 0;
  int underflow_count   = 0;
  int checked_count     = 0;

  stack_with_minimum_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .top_value_o  (top_value_o),
    .min_value_o  (min_value_o),
    .is_empty_o   (is_empty_o),
    .occupancy_o  (occupancy_o),
    .status_o     (status_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one request to the shadow stacks and return the resulting view.
  task automatic predict_stack_view(input logic [REQ_W-1:0] kind,
                                    input logic signed [DATA_W-1:0] value,
                                    output stack_view_t view);
    logic                     joins_minima;
    logic signed [DATA_W-1:0] leaving;
    view.status = ST_OK;
    if (kind == REQ_PUSH) begin
      push_count++;
      if (shadow_count >= STACK_DEPTH) begin
        view.status = ST_OVERFLOW;
        overflow_count++;
      end else begin
        // Equal values also join the minima stack so duplicates pop cleanly.
        joins_minima = (shadow_min_count == 0) ||
                       (value <= shadow_minima[shadow_min_count - 1]);
        if (joins_minima && shadow_min_count < STACK_DEPTH) begin
          shadow_minima[shadow_min_count] = value;
          shadow_min_count++;
        end
        shadow_values[shadow_count] = value;
        shadow_count++;
      end
    end else if (kind == REQ_POP) begin
      pop_count++;
      if (shadow_count == 0) begin
        view.status = ST_UNDERFLOW;
        underflow_count++;
      end else begin
        leaving = shadow_values[shadow_count - 1];
        if (shadow_min_count > 0 && shadow_minima[shadow_min_count - 1] == leaving)
          shadow_min_count--;
        shadow_count--;
      end
    end else begin
      peek_count++;
    end

    // An empty stack reads all ones for both top and minimum.
    view.top_value = '1;
    view.min_value = '1;
    if (shadow_count > 0) begin
      view.top_value = shadow_values[shadow_count - 1];
      if (shadow_min_count > 0)
        view.min_value = shadow_minima[shadow_min_count - 1];
    end
    view.is_empty  = (shadow_count == 0);
    view.occupancy = shadow_count[OCC_W-1:0];
  endtask

  // Offer one request, wait for it to be taken, and record its expected view.
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic signed [DATA_W-1:0] value);
    int          gap;
    stack_view_t view;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    push_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    predict_stack_view(kind, value, view);
    last_status = view.status;
    pending_views.push_back(view);
  endtask

  // Small values give many duplicates and equal minima; extremes hit the edges.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35)
      return $urandom_range(0, 16) - 8;
    if (roll < 55) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [REQ_W-1:0] pick_request(input traffic_e shape);
    int unsigned roll;
    logic [REQ_W-1:0] heavy, light;
    roll  = $urandom_range(0, 99);
    heavy = (shape == TRAFFIC_DRAIN) ? REQ_POP : REQ_PUSH;
    light = (shape == TRAFFIC_DRAIN) ? REQ_PUSH : REQ_POP;
    if (shape == TRAFFIC_MIXED) begin
      if (roll < 40) return REQ_PUSH;
      if (roll < 80) return REQ_POP;
      if (roll < 95) return REQ_PEEK;
      return REQ_UNUSED;
    end
    if (roll < 75) return heavy;
    if (roll < 85) return light;
    if (roll < 95) return REQ_PEEK;
    return REQ_UNUSED;
  endfunction

  // Requests on an empty stack: refused pop, peek and the unused code.
  task automatic test_empty_requests();
    send_request(REQ_POP, pick_value());
    send_request(REQ_PEEK, pick_value());
    send_request(REQ_UNUSED, pick_value());
    send_request(REQ_POP, 32'hFFFF_FFFF);
  endtask

  // Extreme values, a repeated minimum and a drain past empty.
  task automatic test_value_extremes();
    send_request(REQ_PUSH, 32'h7FFF_FFFF);
    send_request(REQ_PUSH, 32'h8000_0000);
    send_request(REQ_PUSH, 32'h8000_0000);
    send_request(REQ_PUSH, 32'hFFFF_FFFF);
    send_request(REQ_PUSH, 32'h0000_0000);
    send_request(REQ_PEEK, 32'h5555_5555);
    send_request(REQ_UNUSED, 32'hAAAA_AAAA);
    repeat (6) send_request(REQ_POP, pick_value());
  endtask

  // A stored minus one looks like the empty reading but is not empty.
  task automatic test_stored_minus_one();
    send_request(REQ_PUSH, 32'hFFFF_FFFF);
    send_request(REQ_PEEK, '0);
    send_request(REQ_POP, '0);
  endtask

  // The receiver holds off for a long stretch while pushes keep coming.
  task automatic test_receiver_hold();
    hold_requested = 1'b1;
    repeat (12) send_request(REQ_PUSH, pick_value());
    send_request(REQ_PEEK, pick_value());
  endtask

  // Random traffic that cycles between filling past full, draining past
  // empty and an even mix.
  task automatic run_random_requests(input int items);
    traffic_e shape;
    int       bound_hits;
    int       mixed_left;
    shape      = TRAFFIC_FILL;
    bound_hits = 0;
    mixed_left = 0;
    for (int n = 0; n < items; n++) begin
      send_request(pick_request(shape), pick_value());
      case (shape)
        TRAFFIC_FILL: begin
          if (last_status == ST_OVERFLOW) bound_hits++;
          if (bound_hits >= 2) begin
            shape      = TRAFFIC_DRAIN;
            bound_hits = 0;
          end
        end
        TRAFFIC_DRAIN: begin
          if (last_status == ST_UNDERFLOW) bound_hits++;
          if (bound_hits >= 2) begin
            shape      = TRAFFIC_MIXED;
            bound_hits = 0;
            mixed_left = $urandom_range(10, 40);
          end
        end
        default: begin
          mixed_left--;
          if (mixed_left <= 0) shape = TRAFFIC_FILL;
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Receiver: random stalls, or one long hold-off when a test asks for it.
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_requested) begin
        hold_requested = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expected view.
  always @(posedge clk_i) begin : result_check
    stack_view_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_views.size() == 0) begin
        mismatch_count++;
        $error("result with no request waiting for it");
      end else begin
        want = pending_views.pop_front();
        checked_count++;
        check_field("top_value", want.top_value, top_value_o);
        check_field("min_value", want.min_value, min_value_o);
        check_field("is_empty", want.is_empty, is_empty_o);
        check_field("occupancy", want.occupancy, occupancy_o);
        check_field("status", want.status, status_o);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender idles lightly, receiver heavily.
    sender_idle_pct   = 18;
    receiver_idle_pct = 47;
    test_empty_requests();
    test_value_extremes();
    test_stored_minus_one();
    test_receiver_hold();
    run_random_requests(PHASE_ITEMS);

    // Sender idles heavily, receiver lightly.
    sender_idle_pct   = 47;
    receiver_idle_pct = 18;
    run_random_requests(PHASE_ITEMS);

    // Back to back on both sides.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_random_requests(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TAIL) @(posedge clk_i);

    $display("Ran %0d pushes, %0d pops and %0d peeks; %0d results compared.",
             push_count, pop_count, peek_count, checked_count);
    $display("Full stack refused %0d pushes, empty stack refused %0d pops.",
             overflow_count, underflow_count);
    if (mismatch_count == 0 && pending_views.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
